/* rtl/uccm_pkg.sv */
// Package for the Unicode case classifier and mapper.
// Holds the code point type, the rule kinds and the irregular pair table.
`default_nettype none
package uccm_pkg;

    typedef logic [20:0] cp_t;

    // How the map stage builds a form from the code point.
    typedef enum logic [2:0] {
        OP_KEEP,
        OP_ADD,
        OP_SUB,
        OP_CONST
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [20:0] value;
    } map_op_t;

    // Result of a search of the irregular pair table.
    typedef struct packed {
        logic hit;
        cp_t  partner;
    } pair_hit_t;

    localparam int PairCount = 59;

    function automatic logic [41:0] pair_entry(input int i);
        logic [41:0] r;
        begin
            case (i)
                0:  r = {21'h0181, 21'h0253};
                1:  r = {21'h0182, 21'h0183};
                2:  r = {21'h0184, 21'h0185};
                3:  r = {21'h0186, 21'h0254};
                4:  r = {21'h0187, 21'h0188};
                5:  r = {21'h0189, 21'h0256};
                6:  r = {21'h018A, 21'h0257};
                7:  r = {21'h018B, 21'h018C};
                8:  r = {21'h018E, 21'h0258};
                9:  r = {21'h018F, 21'h0259};
                10: r = {21'h0190, 21'h025B};
                11: r = {21'h0191, 21'h0192};
                12: r = {21'h0193, 21'h0260};
                13: r = {21'h0194, 21'h0263};
                14: r = {21'h0196, 21'h0269};
                15: r = {21'h0197, 21'h0268};
                16: r = {21'h0198, 21'h0199};
                17: r = {21'h019C, 21'h026F};
                18: r = {21'h019D, 21'h0272};
                19: r = {21'h019F, 21'h0275};
                20: r = {21'h01A0, 21'h01A1};
                21: r = {21'h01A2, 21'h01A3};
                22: r = {21'h01A4, 21'h01A5};
                23: r = {21'h01A6, 21'h0280};
                24: r = {21'h01A7, 21'h01A8};
                25: r = {21'h01AC, 21'h01AD};
                26: r = {21'h01AE, 21'h0288};
                27: r = {21'h01AF, 21'h01B0};
                28: r = {21'h01B1, 21'h028A};
                29: r = {21'h01B2, 21'h028B};
                30: r = {21'h01B3, 21'h01B4};
                31: r = {21'h01B5, 21'h01B6};
                32: r = {21'h01B7, 21'h0292};
                33: r = {21'h01B8, 21'h01B9};
                34: r = {21'h01BC, 21'h01BD};
                35: r = {21'h01C4, 21'h01C6};
                36: r = {21'h01C7, 21'h01C9};
                37: r = {21'h01CA, 21'h01CC};
                38: r = {21'h01F1, 21'h01F3};
                39: r = {21'h01F4, 21'h01F5};
                40: r = {21'h01F7, 21'h01BF};
                41: r = {21'h0220, 21'h019E};
                42: r = {21'h023B, 21'h023C};
                43: r = {21'h023D, 21'h019A};
                44: r = {21'h0241, 21'h0242};
                45: r = {21'h0243, 21'h0180};
                46: r = {21'h0244, 21'h0289};
                47: r = {21'h0245, 21'h028C};
                48: r = {21'h0283, 21'h01A9};
                49: r = {21'h02C0, 21'h0294};
                50: r = {21'h2C64, 21'h027D};
                51: r = {21'h2C6D, 21'h0251};
                52: r = {21'h2C6E, 21'h0271};
                53: r = {21'h2C6F, 21'h0250};
                54: r = {21'h2C70, 21'h0252};
                55: r = {21'h2C7E, 21'h023F};
                56: r = {21'h2C7F, 21'h0240};
                57: r = {21'h0A78D, 21'h0265};
                58: r = {21'h0A7AE, 21'h026A};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // With by_lower low the upper column is searched and the lower partner
    // comes back; with by_lower high it is the other way round.
    function automatic pair_hit_t pair_lookup(input cp_t c, input logic by_lower);
        pair_hit_t   r;
        logic [41:0] e;
        begin
            r.hit     = 1'b0;
            r.partner = c;
            for (int i = 0; i < PairCount; i++)
            begin
                e = pair_entry(i);
                if (!r.hit && !by_lower && e[41:21] == c)
                begin
                    r.hit     = 1'b1;
                    r.partner = e[20:0];
                end
                if (!r.hit && by_lower && e[20:0] == c)
                begin
                    r.hit     = 1'b1;
                    r.partner = e[41:21];
                end
            end
            return r;
        end
    endfunction

    function automatic logic inr(input cp_t c, input cp_t lo, input cp_t hi);
        return (c >= lo) && (c <= hi);
    endfunction

endpackage
`default_nettype wire

/* rtl/uccm_rules.sv */
// Rule decode stage logic: turns a code point into lower and upper map operations.
// Pure combinational; takes the registered pair table hits; uses uccm_pkg.
`default_nettype none
module uccm_rules (
    input  wire uccm_pkg::cp_t       cp,
    input  wire uccm_pkg::pair_hit_t lo_pair,
    input  wire uccm_pkg::pair_hit_t up_pair,
    output uccm_pkg::map_op_t        lo_op,
    output uccm_pkg::map_op_t        up_op
);
    import uccm_pkg::*;

    logic lo_hit;
    logic up_hit;
    cp_t  lo_partner;
    cp_t  up_partner;
    logic odd;
    logic ev;

    assign odd = cp[0];
    assign ev  = ~cp[0];

    // The pair table was searched one stage earlier.
    assign lo_hit     = lo_pair.hit;
    assign lo_partner = lo_pair.partner;
    assign up_hit     = up_pair.hit;
    assign up_partner = up_pair.partner;

    function automatic map_op_t mk(input op_kind_t k, input int v);
        map_op_t m;
        begin
            m.kind  = k;
            m.value = 21'(v);
            return m;
        end
    endfunction

    always_comb
    begin
        lo_op = mk(OP_KEEP, 0);
        if (cp >= 21'h41 && cp <= 21'h5A) lo_op = mk(OP_ADD, 'h20);
        else if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7) lo_op = mk(OP_ADD, 'h20);
        else if (cp >= 21'h100 && cp <= 21'h17D &&
                 ((inr(cp, 21'h100, 21'h136) && ev) || (inr(cp, 21'h139, 21'h147) && odd) ||
                  (inr(cp, 21'h14A, 21'h176) && ev) || (inr(cp, 21'h179, 21'h17D) && odd)))
            lo_op = mk(OP_ADD, 1);
        else if (cp == 21'h178) lo_op = mk(OP_CONST, 'hFF);
        else if (cp >= 21'h181 && lo_hit)
        begin
            lo_op.kind  = OP_CONST;
            lo_op.value = lo_partner;
        end
        else if (cp >= 21'h181 && cp <= 21'h24E &&
                 ((inr(cp, 21'h1CD, 21'h1DB) && odd) ||
                  ((inr(cp, 21'h1DE, 21'h1EE) || inr(cp, 21'h1F8, 21'h1FE) ||
                    inr(cp, 21'h200, 21'h21E) || inr(cp, 21'h222, 21'h232) ||
                    inr(cp, 21'h246, 21'h24E)) && ev)))
            lo_op = mk(OP_ADD, 1);
        else if (cp == 21'h386) lo_op = mk(OP_CONST, 'h3AC);
        else if (inr(cp, 21'h388, 21'h38A)) lo_op = mk(OP_ADD, 'h25);
        else if (cp == 21'h38C) lo_op = mk(OP_CONST, 'h3CC);
        else if (cp == 21'h38E) lo_op = mk(OP_CONST, 'h3CD);
        else if (cp == 21'h38F) lo_op = mk(OP_CONST, 'h3CE);
        else if (inr(cp, 21'h391, 21'h3A1) || inr(cp, 21'h3A3, 21'h3AB))
            lo_op = mk(OP_ADD, 'h20);
        else if (inr(cp, 21'h3E2, 21'h3EE) && ev) lo_op = mk(OP_ADD, 1);
        else if (inr(cp, 21'h401, 21'h40C)) lo_op = mk(OP_ADD, 'h50);
        else if (cp == 21'h40E) lo_op = mk(OP_CONST, 'h45E);
        else if (cp == 21'h40F) lo_op = mk(OP_CONST, 'h45F);
        else if (inr(cp, 21'h410, 21'h42F)) lo_op = mk(OP_ADD, 'h20);
        else if (((inr(cp, 21'h460, 21'h480) || inr(cp, 21'h490, 21'h4BE) ||
                   inr(cp, 21'h4D0, 21'h4EA) || inr(cp, 21'h4EE, 21'h4F4)) && ev) ||
                 cp == 21'h4C1 || cp == 21'h4C3 || cp == 21'h4C7 || cp == 21'h4CB ||
                 cp == 21'h4F8)
            lo_op = mk(OP_ADD, 1);
        else if (inr(cp, 21'h531, 21'h556) || inr(cp, 21'h10A0, 21'h10C5))
            lo_op = mk(OP_ADD, 'h30);
        else if ((inr(cp, 21'h1E00, 21'h1E94) || inr(cp, 21'h1EA0, 21'h1EF8)) && ev)
            lo_op = mk(OP_ADD, 1);
        else if (cp == 21'h1E9E) lo_op = mk(OP_CONST, 'hDF);
        else if (inr(cp, 21'h1F08, 21'h1F0F) || inr(cp, 21'h1F18, 21'h1F1D) ||
                 inr(cp, 21'h1F28, 21'h1F2F) || inr(cp, 21'h1F38, 21'h1F3F) ||
                 inr(cp, 21'h1F48, 21'h1F4D) || (inr(cp, 21'h1F59, 21'h1F5F) && odd) ||
                 inr(cp, 21'h1F68, 21'h1F6F) || inr(cp, 21'h1F88, 21'h1F8F) ||
                 inr(cp, 21'h1F98, 21'h1F9F) || inr(cp, 21'h1FA8, 21'h1FAF) ||
                 inr(cp, 21'h1FB8, 21'h1FB9) || inr(cp, 21'h1FD8, 21'h1FD9) ||
                 inr(cp, 21'h1FE8, 21'h1FE9))
            lo_op = mk(OP_SUB, 8);
        else if (inr(cp, 21'h24B6, 21'h24CF)) lo_op = mk(OP_ADD, 'h1A);
        else if (inr(cp, 21'hFF21, 21'hFF3A)) lo_op = mk(OP_ADD, 'h20);
    end

    always_comb
    begin
        up_op = mk(OP_KEEP, 0);
        if (inr(cp, 21'h61, 21'h7A)) up_op = mk(OP_SUB, 'h20);
        else if (cp == 21'hDF) up_op = mk(OP_CONST, 'h1E9E);
        else if (inr(cp, 21'hE0, 21'hFE) && cp != 21'hF7) up_op = mk(OP_SUB, 'h20);
        else if (cp == 21'hFF) up_op = mk(OP_CONST, 'h178);
        else if (((inr(cp, 21'h101, 21'h137) || inr(cp, 21'h14B, 21'h177)) && odd) ||
                 ((inr(cp, 21'h13A, 21'h148) || inr(cp, 21'h17A, 21'h17E)) && ev))
            up_op = mk(OP_SUB, 1);
        else if (cp >= 21'h180 && up_hit)
        begin
            up_op.kind  = OP_CONST;
            up_op.value = up_partner;
        end
        else if ((inr(cp, 21'h1CE, 21'h1DC) && ev) ||
                 ((inr(cp, 21'h1DF, 21'h1EF) || inr(cp, 21'h1F9, 21'h21F) ||
                   inr(cp, 21'h223, 21'h233) || inr(cp, 21'h247, 21'h24F)) && odd))
            up_op = mk(OP_SUB, 1);
        else if (cp == 21'h3AC) up_op = mk(OP_CONST, 'h386);
        else if (inr(cp, 21'h3AD, 21'h3AF)) up_op = mk(OP_SUB, 'h25);
        else if (inr(cp, 21'h3B1, 21'h3C1) || inr(cp, 21'h3C3, 21'h3CB))
            up_op = mk(OP_SUB, 'h20);
        else if (cp == 21'h3CC) up_op = mk(OP_CONST, 'h38C);
        else if (cp == 21'h3CD) up_op = mk(OP_CONST, 'h38E);
        else if (cp == 21'h3CE) up_op = mk(OP_CONST, 'h38F);
        else if (inr(cp, 21'h3E3, 21'h3EF) && odd) up_op = mk(OP_SUB, 1);
        else if (inr(cp, 21'h430, 21'h44F)) up_op = mk(OP_SUB, 'h20);
        else if (inr(cp, 21'h451, 21'h45C)) up_op = mk(OP_SUB, 'h50);
        else if (cp == 21'h45E) up_op = mk(OP_CONST, 'h40E);
        else if (cp == 21'h45F) up_op = mk(OP_CONST, 'h40F);
        else if (((inr(cp, 21'h461, 21'h481) || inr(cp, 21'h491, 21'h4BF) ||
                   inr(cp, 21'h4D1, 21'h4EB) || inr(cp, 21'h4EF, 21'h4F5)) && odd) ||
                 cp == 21'h4C2 || cp == 21'h4C4 || cp == 21'h4C8 || cp == 21'h4CC ||
                 cp == 21'h4F9)
            up_op = mk(OP_SUB, 1);
        else if (inr(cp, 21'h561, 21'h586) || inr(cp, 21'h10D0, 21'h10F5))
            up_op = mk(OP_SUB, 'h30);
        else if ((inr(cp, 21'h1E01, 21'h1E95) || inr(cp, 21'h1EA1, 21'h1EF9)) && odd)
            up_op = mk(OP_SUB, 1);
        else if (inr(cp, 21'h1F00, 21'h1F07) || inr(cp, 21'h1F10, 21'h1F15) ||
                 inr(cp, 21'h1F20, 21'h1F27) || inr(cp, 21'h1F30, 21'h1F37) ||
                 inr(cp, 21'h1F40, 21'h1F45) || (inr(cp, 21'h1F51, 21'h1F57) && odd) ||
                 inr(cp, 21'h1F60, 21'h1F67) || inr(cp, 21'h1F80, 21'h1F87) ||
                 inr(cp, 21'h1F90, 21'h1F97) || inr(cp, 21'h1FA0, 21'h1FA7) ||
                 inr(cp, 21'h1FB0, 21'h1FB1) || inr(cp, 21'h1FD0, 21'h1FD1) ||
                 inr(cp, 21'h1FE0, 21'h1FE1))
            up_op = mk(OP_ADD, 8);
        else if (inr(cp, 21'h24D0, 21'h24E9)) up_op = mk(OP_SUB, 'h1A);
        else if (inr(cp, 21'hFF41, 21'hFF5A)) up_op = mk(OP_SUB, 'h20);
    end

endmodule
`default_nettype wire

/* rtl/unicode_case_classify_and_map.sv */
// Top level of the Unicode case classifier and mapper: a three-stage pipeline.
// Uses uccm_pkg and uccm_rules.
//
//  channel | signals                                   | direction
//  input   | valid, stall, code_point                  | item in
//  output  | out_valid, out_stall, is_lower_case,      | item out
//          | is_upper_case, lower_form, upper_form     |
//
// One item per cycle while out_stall is low; stages in order: pair lookup, rule decode, form.
// Reset clears the stage valid bits only; data registers are not reset.
// A stage advances when it is empty or the next one does, the last when it is
// empty or taken; an output stall freezes full stages up to a bubble, squeezed out.
`default_nettype none
module unicode_case_classify_and_map (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         valid,
    output logic        stall,
    input  wire  [20:0] code_point,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        is_lower_case,
    output logic        is_upper_case,
    output logic [20:0] lower_form,
    output logic [20:0] upper_form
);
    import uccm_pkg::*;

    logic      s1_v_reg, s2_v_reg, s3_v_reg;
    cp_t       s1_cp_reg, s2_cp_reg;
    pair_hit_t s1_lo_pair_reg, s1_up_pair_reg;
    map_op_t   s2_lo_reg, s2_up_reg;
    cp_t       s3_lo_reg, s3_up_reg, s3_cp_reg;
    map_op_t   lo_op_next, up_op_next;
    logic      en3, en2, en1;

    assign en3   = !s3_v_reg || !out_stall;
    assign en2   = !s2_v_reg || en3;
    assign en1   = !s1_v_reg || en2;
    assign stall = !en1;

    uccm_rules u_rules (
        .cp      (s1_cp_reg),
        .lo_pair (s1_lo_pair_reg),
        .up_pair (s1_up_pair_reg),
        .lo_op   (lo_op_next),
        .up_op   (up_op_next)
    );

    function automatic cp_t apply(input map_op_t m, input cp_t c);
        cp_t r;
        begin
            case (m.kind)
                OP_ADD:   r = c + m.value;
                OP_SUB:   r = c - m.value;
                OP_CONST: r = m.value;
                default:  r = c;
            endcase
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_v_reg <= valid;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cp_reg      <= code_point;
            s1_lo_pair_reg <= pair_lookup(code_point, 1'b0);
            s1_up_pair_reg <= pair_lookup(code_point, 1'b1);
        end
        if (en2)
        begin
            s2_cp_reg <= s1_cp_reg;
            s2_lo_reg <= lo_op_next;
            s2_up_reg <= up_op_next;
        end
        if (en3)
        begin
            s3_cp_reg <= s2_cp_reg;
            s3_lo_reg <= apply(s2_lo_reg, s2_cp_reg);
            s3_up_reg <= apply(s2_up_reg, s2_cp_reg);
        end
    end

    assign out_valid     = s3_v_reg;
    assign lower_form    = s3_lo_reg;
    assign upper_form    = s3_up_reg;
    assign is_lower_case = (s3_up_reg != s3_cp_reg);
    assign is_upper_case = (s3_lo_reg != s3_cp_reg);

`ifndef ASSERT_OFF
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lower_form) && $stable(upper_form))
        else $error("output item changed while stalled");
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_v_reg |-> !stall)
        else $error("input stalled with empty last stage");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_lower_case && is_upper_case))
        else $error("item flagged both lower and upper");
`endif

endmodule
`default_nettype wire
